[rtl/hash_set_insert_unique_assert.svh]
// Assertion macros for the block's top-level RTL.
`ifndef HASH_SET_INSERT_UNIQUE_ASSERT_SVH
`define HASH_SET_INSERT_UNIQUE_ASSERT_SVH

// Implication checked at every clock edge, disabled while reset is asserted.
`define HSIU_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HSIU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/hsiu_pkg.sv]
package hsiu_pkg;

	localparam int MaxBuckets = 256;
	localparam int PoolNodes  = 1024;
	localparam int BktW  = $clog2(MaxBuckets);
	localparam int NodeW = $clog2(PoolNodes);
	localparam int CntW  = NodeW + 1;
	localparam int CfgW  = 9;

	typedef struct packed {
		logic [31:0] value_ref;
		logic [31:0] key_hash;
	} in_item_t;

	typedef struct packed {
		logic [9:0]  node_index;
		logic        inserted;
		logic        table_full;
		logic [10:0] entry_count;
	} out_item_t;

	// Handshake between the sequencer and the remainder unit.
	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic done;
	} div_sts_t;

endpackage

[rtl/hsiu_mod.sv]
// Restoring remainder: one quotient bit per cycle.
module hsiu_mod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hsiu_pkg::div_ctl_t           ctl,
	input  logic [31:0]                  dividend,
	input  logic [hsiu_pkg::CfgW-1:0]    divisor,
	output hsiu_pkg::div_sts_t           sts,
	output logic [hsiu_pkg::BktW-1:0]    remainder
);
	import hsiu_pkg::*;

	logic [31:0]     num_q;
	logic [CfgW-1:0] den_q;
	logic [CfgW-1:0] rem_q;
	logic [5:0]      cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [CfgW:0]   trial;
	logic [CfgW:0]   diff;

	assign trial = {rem_q, num_q[31]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder stays below the divisor, so it fits in CfgW bits.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[30:0], 1'b0};
			rem_q <= diff[CfgW] ? trial[CfgW-1:0] : diff[CfgW-1:0];
		end
	end

	assign sts.done  = done_q;
	assign remainder = rem_q[BktW-1:0];
endmodule

[rtl/hsiu_store.sv]
// Node pool and bucket head storage. Reads are registered.
module hsiu_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [hsiu_pkg::BktW-1:0]     head_addr,
	output logic                          head_valid,
	output logic [hsiu_pkg::NodeW-1:0]    head_node,
	input  logic                          head_we,
	input  logic [hsiu_pkg::NodeW-1:0]    head_wdata,
	input  logic [hsiu_pkg::NodeW-1:0]    node_addr,
	output logic [31:0]                   node_ref,
	output logic [31:0]                   node_hash,
	output logic                          node_lvalid,
	output logic [hsiu_pkg::NodeW-1:0]    node_link,
	input  logic                          node_we,
	input  logic [hsiu_pkg::NodeW-1:0]    node_waddr,
	input  logic [31:0]                   wr_ref,
	input  logic [31:0]                   wr_hash,
	input  logic                          wr_lvalid,
	input  logic [hsiu_pkg::NodeW-1:0]    wr_link
);
	import hsiu_pkg::*;

	logic [MaxBuckets-1:0] hvalid_q;
	logic [NodeW-1:0]      head_mem [MaxBuckets];
	logic [64+NodeW:0]     node_mem [PoolNodes];
	logic [64+NodeW:0]     nrd_q;
	logic                  hv_q;
	logic [NodeW-1:0]      hn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvalid_q <= '0;
			hv_q     <= 1'b0;
		end else begin
			hv_q <= hvalid_q[head_addr];
			if (head_we) hvalid_q[head_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		hn_q <= head_mem[head_addr];
		if (head_we) head_mem[head_addr] <= head_wdata;
	end

	always_ff @(posedge clk) begin
		nrd_q <= node_mem[node_addr];
		if (node_we) node_mem[node_waddr] <= {wr_ref, wr_hash, wr_lvalid, wr_link};
	end

	assign head_valid  = hv_q;
	assign head_node   = hn_q;
	assign node_ref    = nrd_q[64+NodeW:33+NodeW];
	assign node_hash   = nrd_q[32+NodeW:1+NodeW];
	assign node_lvalid = nrd_q[NodeW];
	assign node_link   = nrd_q[NodeW-1:0];
endmodule

[rtl/hash_set_insert_unique.sv]
// Unique insert into a chained hash table of value references.
// Input channel in_valid/in_ready carries one beat {value_ref, key_hash}.
// Output channel out_valid/out_ready returns exactly one beat per input:
// {node_index, inserted, table_full, entry_count}.
// cfg_we/cfg_data write bucket_count (0 acts as 1, above 256 as 256);
// write it only while the block is idle.
// Sequence: the bucket remainder (bit-serial, one bit a cycle), the head
// read, then a registered read of each chain node visited; on a miss a
// final state writes back the new node (unless the pool is full) and loads
// the result, on a match the result is loaded as the node is compared.
// One item at a time: in_ready is high only when the block is idle and the
// output register is empty.
// Reset clears all bucket heads (per-bucket valid bits), the entry count and
// the sequencer; no clearing pass is needed. bucket_count resets to 256.
// A stalled receiver holds the result in the output register; no new beat
// is taken until it is delivered.
module hash_set_insert_unique (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hsiu_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output hsiu_pkg::out_item_t  out_data,
	input  logic                 cfg_we,
	input  logic [8:0]           cfg_data
);
	import hsiu_pkg::*;
	`include "hash_set_insert_unique_assert.svh"

	typedef enum logic [2:0] {
		S_IDLE, S_DIV, S_HEAD, S_HWAIT, S_NODE, S_NWAIT, S_DONE
	} state_t;

	state_t          state_q;
	logic [CfgW-1:0] bcount_q;
	logic [31:0]     ref_q;
	logic [31:0]     hash_q;
	logic [BktW-1:0] bkt_q;
	logic [NodeW-1:0] node_q;
	logic [CntW-1:0] count_q;
	logic [NodeW:0]  steps_q;
	logic            ov_q;
	out_item_t       od_q;

	div_ctl_t        dctl;
	div_sts_t        dsts;
	logic [BktW-1:0] rem;
	logic [CfgW-1:0] eff_div;
	logic [31:0]     in_hash;

	logic             hv;
	logic [NodeW-1:0] hn;
	logic [31:0]      n_ref;
	logic [31:0]      n_hash;
	logic             n_lv;
	logic [NodeW-1:0] n_link;
	logic             head_we;
	logic             node_we;
	logic             match;
	logic             full;

	// Clamp the divisor into 1..MaxBuckets.
	always_comb begin
		eff_div = bcount_q;
		if (bcount_q == '0) eff_div = CfgW'(1);
		if (bcount_q > CfgW'(MaxBuckets)) eff_div = CfgW'(MaxBuckets);
	end

	assign in_hash   = (in_data.value_ref == '0) ? '0 : in_data.key_hash;
	assign in_ready  = (state_q == S_IDLE) && !ov_q;
	assign dctl.start = in_valid && in_ready;

	hsiu_mod u_mod (
		.clk(clk), .arst_n(arst_n), .ctl(dctl), .dividend(in_hash),
		.divisor(eff_div), .sts(dsts), .remainder(rem)
	);

	assign full = count_q >= CntW'(PoolNodes);
	assign match = (n_ref != '0 && ref_q != '0) ? (n_hash == hash_q) : (n_ref == ref_q);
	assign head_we = (state_q == S_DONE) && !full;
	assign node_we = head_we;

	hsiu_store u_store (
		.clk(clk), .arst_n(arst_n),
		.head_addr(bkt_q), .head_valid(hv), .head_node(hn),
		.head_we(head_we), .head_wdata(count_q[NodeW-1:0]),
		.node_addr(node_q), .node_ref(n_ref), .node_hash(n_hash),
		.node_lvalid(n_lv), .node_link(n_link),
		.node_we(node_we), .node_waddr(count_q[NodeW-1:0]),
		.wr_ref(ref_q), .wr_hash(hash_q), .wr_lvalid(hv), .wr_link(hn)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			bcount_q <= CfgW'(MaxBuckets);
			count_q  <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (cfg_we) bcount_q <= cfg_data;
			if (ov_q && out_ready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (dctl.start) state_q <= S_DIV;
				end
				S_DIV: begin
					if (dsts.done) state_q <= S_HEAD;
				end
				S_HEAD: state_q <= S_HWAIT;
				S_HWAIT: begin
					// head read is now on hv/hn
					if (hv) state_q <= S_NODE;
					else state_q <= S_DONE;
				end
				S_NODE: state_q <= S_NWAIT;
				S_NWAIT: begin
					if (match) begin
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end else if (n_lv && steps_q < (NodeW+1)'(PoolNodes - 1)) begin
						state_q <= S_NODE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					ov_q <= 1'b1;
					if (!full) count_q <= count_q + CntW'(1);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				ref_q  <= in_data.value_ref;
				hash_q <= in_hash;
			end
			S_DIV: begin
				if (dsts.done) bkt_q <= rem;
			end
			S_HWAIT: begin
				node_q  <= hn;
				steps_q <= '0;
			end
			S_NWAIT: begin
				node_q  <= n_link;
				steps_q <= steps_q + (NodeW+1)'(1);
				od_q.node_index  <= 10'(node_q);
				od_q.inserted    <= 1'b0;
				od_q.table_full  <= 1'b0;
				od_q.entry_count <= 11'(count_q);
			end
			S_DONE: begin
				od_q.node_index  <= full ? '0 : 10'(count_q);
				od_q.inserted    <= !full;
				od_q.table_full  <= full;
				od_q.entry_count <= full ? 11'(count_q) : 11'(count_q + CntW'(1));
			end
			default: ;
		endcase
	end

	assign out_valid = ov_q;
	assign out_data  = od_q;

	`HSIU_ASSERT_IMPL(a_count_max, 1'b1, count_q <= CntW'(PoolNodes), "entry count over pool")
	`HSIU_ASSERT_IMPL(a_busy_not_ready, state_q != S_IDLE, !in_ready, "ready while busy")
	`HSIU_ASSERT_NEXT(a_done_result, state_q == S_DONE, ov_q, "no result after insert")
	`HSIU_ASSERT_IMPL(a_full_flags, ov_q && od_q.table_full, !od_q.inserted, "full and inserted")
endmodule
